// ===== sv/emacs_line_editor_top_defines.svh =====
// Assertion macros for the line editor.
`ifndef EMACS_LINE_EDITOR_TOP_DEFINES_SVH
`define EMACS_LINE_EDITOR_TOP_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define EMLE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("line editor invariant violated");

// Implication checked in the same cycle.
`define EMLE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line editor implication violated");

`endif

// ===== sv/emle_pkg.sv =====
// Shared types, key codes and decode functions for the line editor.
package emle_pkg;

  localparam int LINE_LEN_DEF = 64;
  localparam int CHAR_W       = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CHAR_W-1:0] K_NONE     = 8'h00;
  localparam logic [CHAR_W-1:0] K_CTRL_A   = 8'h01;
  localparam logic [CHAR_W-1:0] K_CTRL_B   = 8'h02;
  localparam logic [CHAR_W-1:0] K_CTRL_C   = 8'h03;
  localparam logic [CHAR_W-1:0] K_CTRL_D   = 8'h04;
  localparam logic [CHAR_W-1:0] K_CTRL_E   = 8'h05;
  localparam logic [CHAR_W-1:0] K_CTRL_F   = 8'h06;
  localparam logic [CHAR_W-1:0] K_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] K_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] K_CTRL_K   = 8'h0B;
  localparam logic [CHAR_W-1:0] K_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] K_CTRL_U   = 8'h15;
  localparam logic [CHAR_W-1:0] K_CTRL_W   = 8'h17;
  localparam logic [CHAR_W-1:0] K_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] K_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] K_TILDE    = 8'h7E;
  localparam logic [CHAR_W-1:0] K_DEL      = 8'h7F;
  localparam logic [CHAR_W-1:0] K_HIGH_LO  = 8'h80;
  localparam logic [CHAR_W-1:0] K_HIGH_HI  = 8'hFE;
  localparam logic [CHAR_W-1:0] K_END_MARK = 8'hFF;

  localparam logic [CHAR_W-1:0] X_LEFT   = 8'd75;
  localparam logic [CHAR_W-1:0] X_RIGHT  = 8'd77;
  localparam logic [CHAR_W-1:0] X_HOME   = 8'd115;
  localparam logic [CHAR_W-1:0] X_HOME2  = 8'd71;
  localparam logic [CHAR_W-1:0] X_END    = 8'd116;
  localparam logic [CHAR_W-1:0] X_END2   = 8'd79;
  localparam logic [CHAR_W-1:0] X_DELETE = 8'd83;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXT_PREFIX = 1'b0,
    REG_EOF_EMPTY  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_END   = 2'd2,
    KIND_EOF   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              intr;
  } res_t;

  function automatic logic [CHAR_W-1:0] map_ext(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] r;
    case (code)
      X_LEFT:           r = K_CTRL_B;
      X_RIGHT:          r = K_CTRL_F;
      X_HOME, X_HOME2:  r = K_CTRL_A;
      X_END, X_END2:    r = K_CTRL_E;
      X_DELETE:         r = K_CTRL_D;
      default:          r = K_NONE;
    endcase
    return r;
  endfunction

  function automatic logic is_insertable(input logic [CHAR_W-1:0] c);
    return (c inside {[K_SPACE:K_TILDE], [K_HIGH_LO:K_HIGH_HI]});
  endfunction

endpackage

// ===== sv/emle_ram.sv =====
// Line store: one write port and one registered read port.
module emle_ram #(
  parameter int DEPTH = emle_pkg::LINE_LEN_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [emle_pkg::CHAR_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [emle_pkg::CHAR_W-1:0] rdata
);

  logic [emle_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/emacs_line_editor_top.sv =====
// Emacs-style line editor: key bytes in, edited line words out on submit.
//
// One key word is taken at a time; in_stall stays high until its work is
// done. Cursor moves, ^K, ^U and ignored keys finish without leaving idle.
// An insert shifts the entries from the cursor up one place and then
// writes the key, and a delete shifts the entries after it down one place,
// since the line store has one write and one read port and the shift walks
// it one entry a cycle. A submitted line is read and sent one byte at a
// time, held by any output stall, and ^W reads back from the cursor one
// byte at a time. No clearing pass is needed after reset. A single-word
// result (empty line, end marker, end by ^D) waits out any output stall
// and sits in the output register while the block returns to idle.
module emacs_line_editor_top #(
  parameter int LINE_LEN = emle_pkg::LINE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [emle_pkg::CHAR_W-1:0]     in_key_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [emle_pkg::CHAR_W-1:0]     out_char_out,
  output logic                            out_last,
  output logic                            out_interrupted,
  input  logic                            cfg_we,
  input  logic [emle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emle_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `include "emacs_line_editor_top_defines.svh"

  localparam int LW = $clog2(LINE_LEN + 1);
  localparam int AW = $clog2(LINE_LEN);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_INS_SHIFT = 9'b000000010,
    ST_INS_PUT   = 9'b000000100,
    ST_DEL_SHIFT = 9'b000001000,
    ST_SUB_RD    = 9'b000010000,
    ST_SUB_OUT   = 9'b000100000,
    ST_WD_RD     = 9'b001000000,
    ST_WD_CHK    = 9'b010000000,
    ST_EMIT      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] cursor_r, cursor_nxt;
  logic [LW-1:0] length_r, length_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          prefix_seen_r, prefix_nxt;
  logic          wpend_r, wpend_nxt;
  logic          intr_r, intr_nxt;
  logic          skip_r, skip_nxt;
  logic [emle_pkg::CHAR_W-1:0] key_r, key_nxt;
  emle_pkg::res_t pend_res_r, pend_res_nxt;
  emle_pkg::res_t out_res_r, out_res_nxt;
  logic          out_valid_r;
  logic          out_load;
  logic          out_free;

  logic [emle_pkg::CHAR_W-1:0] cfg_prefix_r;
  logic                        cfg_eof_r;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [emle_pkg::CHAR_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [emle_pkg::CHAR_W-1:0] ram_rdata;

  logic [LW-1:0] idx_inc;
  logic [LW-1:0] idx_dec;
  logic [LW-1:0] cursor_dec;
  logic [emle_pkg::CHAR_W-1:0] code;
  logic do_cmd;
  logic do_submit;
  logic sub_intr;
  logic is_space;
  logic ram_we_ok;

  assign idx_inc    = idx_r + LW'(1);
  assign idx_dec    = idx_r - LW'(1);
  assign cursor_dec = cursor_r - LW'(1);
  assign is_space   = (ram_rdata == emle_pkg::K_SPACE);
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign ram_we_ok  = (state_r == ST_INS_SHIFT) || (state_r == ST_INS_PUT) ||
                      (state_r == ST_DEL_SHIFT);

  emle_ram #(
    .DEPTH(LINE_LEN)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cursor_nxt   = cursor_r;
    length_nxt   = length_r;
    idx_nxt      = idx_r;
    prefix_nxt   = prefix_seen_r;
    wpend_nxt    = wpend_r;
    intr_nxt     = intr_r;
    skip_nxt     = skip_r;
    key_nxt      = key_r;
    pend_res_nxt = pend_res_r;
    out_load     = 1'b0;
    out_res_nxt  = pend_res_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = key_r;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    code         = emle_pkg::K_NONE;
    do_cmd       = 1'b0;
    do_submit    = 1'b0;
    sub_intr     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (prefix_seen_r) begin
            prefix_nxt = 1'b0;
            code       = emle_pkg::map_ext(in_key_byte);
            do_cmd     = 1'b1;
          end else if (in_key_byte == cfg_prefix_r) begin
            prefix_nxt = 1'b1;
          end else if (in_key_byte == emle_pkg::K_END_MARK) begin
            pend_res_nxt = '{kind: emle_pkg::KIND_END, ch: '0, last: 1'b1, intr: 1'b0};
            cursor_nxt   = '0;
            length_nxt   = '0;
            state_nxt    = ST_EMIT;
          end else if (in_key_byte == emle_pkg::K_CTRL_C) begin
            do_submit = 1'b1;
            sub_intr  = 1'b1;
          end else begin
            code   = (in_key_byte == emle_pkg::K_ESC) ? emle_pkg::K_CTRL_U : in_key_byte;
            do_cmd = 1'b1;
          end

          if (do_cmd) begin
            if (emle_pkg::is_insertable(code)) begin
              if (length_r < LW'(LINE_LEN)) begin
                key_nxt   = code;
                idx_nxt   = length_r;
                wpend_nxt = 1'b0;
                state_nxt = ST_INS_SHIFT;
              end
            end else begin
              case (code)
                emle_pkg::K_CTRL_A: cursor_nxt = '0;
                emle_pkg::K_CTRL_B: begin
                  if (cursor_r != '0) begin
                    cursor_nxt = cursor_dec;
                  end
                end
                emle_pkg::K_CTRL_E: cursor_nxt = length_r;
                emle_pkg::K_CTRL_F: begin
                  if (cursor_r < length_r) begin
                    cursor_nxt = cursor_r + LW'(1);
                  end
                end
                emle_pkg::K_CTRL_K: length_nxt = cursor_r;
                emle_pkg::K_DEL, emle_pkg::K_BS: begin
                  if (cursor_r != '0) begin
                    cursor_nxt = cursor_dec;
                    idx_nxt    = cursor_dec;
                    wpend_nxt  = 1'b0;
                    state_nxt  = ST_DEL_SHIFT;
                  end
                end
                emle_pkg::K_CTRL_D: begin
                  if (length_r == '0) begin
                    cursor_nxt = '0;
                    if (cfg_eof_r) begin
                      pend_res_nxt = '{kind: emle_pkg::KIND_EOF, ch: '0, last: 1'b1,
                                       intr: 1'b0};
                      state_nxt    = ST_EMIT;
                    end
                  end else if (cursor_r < length_r) begin
                    idx_nxt   = cursor_r;
                    wpend_nxt = 1'b0;
                    state_nxt = ST_DEL_SHIFT;
                  end
                end
                emle_pkg::K_CTRL_U: begin
                  cursor_nxt = '0;
                  length_nxt = '0;
                end
                emle_pkg::K_CTRL_W: begin
                  skip_nxt  = 1'b1;
                  state_nxt = ST_WD_RD;
                end
                emle_pkg::K_LF, emle_pkg::K_CR: do_submit = 1'b1;
                default: ;
              endcase
            end
          end

          if (do_submit) begin
            intr_nxt = sub_intr;
            if (length_r == '0) begin
              pend_res_nxt = '{kind: emle_pkg::KIND_EMPTY, ch: '0, last: 1'b1,
                               intr: sub_intr};
              cursor_nxt   = '0;
              state_nxt    = ST_EMIT;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_SUB_RD;
            end
          end
        end
      end

      ST_INS_SHIFT: begin
        if (wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_inc[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_r > cursor_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
          idx_nxt   = idx_dec;
          wpend_nxt = 1'b1;
        end else begin
          wpend_nxt = 1'b0;
          state_nxt = ST_INS_PUT;
        end
      end

      ST_INS_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = cursor_r[AW-1:0];
        ram_wdata  = key_r;
        cursor_nxt = cursor_r + LW'(1);
        length_nxt = length_r + LW'(1);
        state_nxt  = ST_IDLE;
      end

      ST_DEL_SHIFT: begin
        if (wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_dec[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_inc < length_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc;
          wpend_nxt = 1'b1;
        end else begin
          wpend_nxt  = 1'b0;
          length_nxt = length_r - LW'(1);
          state_nxt  = ST_IDLE;
        end
      end

      ST_SUB_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
        state_nxt = ST_SUB_OUT;
      end

      ST_SUB_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_res_nxt = '{kind: emle_pkg::KIND_CHAR, ch: ram_rdata,
                          last: (idx_inc == length_r), intr: intr_r};
          if (idx_inc == length_r) begin
            cursor_nxt = '0;
            length_nxt = '0;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_SUB_RD;
          end
        end
      end

      ST_WD_RD: begin
        if (cursor_r == '0) begin
          length_nxt = cursor_r;
          state_nxt  = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cursor_dec[AW-1:0];
          state_nxt = ST_WD_CHK;
        end
      end

      ST_WD_CHK: begin
        if (skip_r) begin
          if (!is_space) begin
            skip_nxt = 1'b0;
          end
          cursor_nxt = cursor_dec;
          state_nxt  = ST_WD_RD;
        end else if (!is_space) begin
          cursor_nxt = cursor_dec;
          state_nxt  = ST_WD_RD;
        end else begin
          length_nxt = cursor_r;
          state_nxt  = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_res_nxt = pend_res_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cursor_r      <= '0;
      length_r      <= '0;
      prefix_seen_r <= 1'b0;
      wpend_r       <= 1'b0;
      skip_r        <= 1'b0;
      intr_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_r      <= cursor_nxt;
      length_r      <= length_nxt;
      prefix_seen_r <= prefix_nxt;
      wpend_r       <= wpend_nxt;
      skip_r        <= skip_nxt;
      intr_r        <= intr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    pend_res_r <= pend_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_prefix_r <= '0;
      cfg_eof_r    <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == emle_pkg::REG_EXT_PREFIX) begin
        cfg_prefix_r <= cfg_wdata;
      end
      if (cfg_index == emle_pkg::REG_EOF_EMPTY) begin
        cfg_eof_r <= cfg_wdata[0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_res_r.kind;
  assign out_char_out    = out_res_r.ch;
  assign out_last        = out_res_r.last;
  assign out_interrupted = out_res_r.intr;

  `EMLE_ASSERT_ALWAYS(a_cursor_in_line, cursor_r <= length_r)
  `EMLE_ASSERT_ALWAYS(a_length_bound, length_r <= LW'(LINE_LEN))
  `EMLE_ASSERT_IMPL(a_write_in_edit, ram_we, ram_we_ok)

endmodule
